@@ hw/rtl/rrts_pkg.sv @@
// Package for the round robin task scheduler core.
// Holds codes, reset values and the controller/datapath structs; no dependencies.
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int SLICE_BITS_DEF = 24;

    localparam logic [23:0] RELOAD_RESET    = 24'hFFFFFF;
    localparam logic [23:0] MIN_SLICE_RESET = 24'd10000;
    localparam logic [4:0]  TASKS_RESET     = 5'd16;

    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_MARKS  = 3'd2;
    localparam logic [2:0] OP_SWITCH = 3'd3;
    localparam logic [2:0] OP_EXPIRE = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [1:0] CFG_RELOAD = 2'd0;
    localparam logic [1:0] CFG_MIN    = 2'd1;
    localparam logic [1:0] CFG_TASKS  = 2'd2;

    typedef struct packed {
        logic latch;
        logic exec_op;
        logic set_rem;
        logic idx_run;
        logic idx_one;
        logic idx_inc;
        logic alloc_do;
        logic alloc_fail;
        logic root_fix;
        logic scan_chk;
        logic charge;
        logic set_run_idx;
        logic set_run_root;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       idx_end;
        logic       hit;
        logic       free;
        logic       any_left;
    } t_sts;

endpackage

@@ hw/rtl/round_robin_task_scheduler_core.sv @@
// Top level of the round robin task scheduler.
// Joins rrts_ctrl and rrts_dp; depends on rrts_pkg.
//
// Usage: raise i_start with an operation on i_opcode, i_task_id, i_exec_mark,
// i_fifo_mode and i_counter_value; the transfer happens when o_busy is low.
// One result follows each operation, shown for one cycle with o_valid high.
// Steps from the accepting edge to the result, T = active slots:
//   delete, set marks, time query, unused codes: dispatch, execute, respond;
//   allocate: probe for a free slot from slot 1, at most up to slot T-1;
//   switch, slice expiry: store the remaining slice, then walk on from the
//   running task; on a wrap to root it refills root, scans and may charge the slots.
// The walk over the task table goes one slot per cycle.
// A new operation is taken in the cycle the result is shown.
// Configuration: i_cfg_valid with i_cfg_index/i_cfg_data, o_cfg_ready always high;
// write only while idle.
// Reset (synchronous, i_rst_n low) restores the table: root used and executing,
// all slices full, run times zero, running task root. The receiver cannot stall.
module round_robin_task_scheduler_core #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int SLICE_BITS = rrts_pkg::SLICE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_task_id,
    input  logic        i_exec_mark,
    input  logic        i_fifo_mode,
    input  logic [23:0] i_counter_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_result_task,
    output logic [3:0]  o_current_task,
    output logic [23:0] o_slice_load,
    output logic        o_tick_enable,
    output logic [63:0] o_task_time,
    output logic [1:0]  o_status
);
    import rrts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rrts_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLICE_BITS (SLICE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_exec_mark     (i_exec_mark),
        .i_fifo_mode     (i_fifo_mode),
        .i_counter_value (i_counter_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_result_task   (o_result_task),
        .o_current_task  (o_current_task),
        .o_slice_load    (o_slice_load),
        .o_tick_enable   (o_tick_enable),
        .o_task_time     (o_task_time),
        .o_status        (o_status)
    );

endmodule

@@ hw/rtl/rrts_ctrl.sv @@
// Controller state machine of the scheduler core.
// Depends on rrts_pkg; drives the datapath through t_cmd and reads t_sts.
module rrts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_cmd o_cmd
);
    import rrts_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_WINIT = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_CHRG  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_ALLOC) begin
                    o_cmd.idx_one = 1'b1;
                    n_state       = S_ALLOC;
                end else if (i_sts.op == OP_SWITCH || i_sts.op == OP_EXPIRE) begin
                    o_cmd.set_rem = 1'b1;
                    n_state       = S_WINIT;
                end else begin
                    o_cmd.exec_op = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_ALLOC: begin
                priority if (i_sts.idx_end) begin
                    o_cmd.alloc_fail = 1'b1;
                    n_state          = S_RESP;
                end else if (i_sts.free) begin
                    o_cmd.alloc_do = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_WINIT: begin
                o_cmd.idx_run = 1'b1;
                n_state       = S_WALK;
            end
            S_WALK: begin
                priority if (i_sts.idx_end) begin
                    // wrap to root: refill root if below the minimum, then look for slice left
                    o_cmd.root_fix = 1'b1;
                    o_cmd.idx_one  = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_sts.hit) begin
                    o_cmd.set_run_idx = 1'b1;
                    n_state           = S_RESP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN: begin
                priority if (i_sts.idx_end && i_sts.any_left) begin
                    o_cmd.set_run_root = 1'b1;
                    n_state            = S_RESP;
                end else if (i_sts.idx_end) begin
                    o_cmd.idx_one = 1'b1;
                    n_state       = S_CHRG;
                end else begin
                    o_cmd.scan_chk = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_CHRG: begin
                if (i_sts.idx_end) begin
                    o_cmd.set_run_root = 1'b1;
                    n_state            = S_RESP;
                end else begin
                    o_cmd.charge  = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/rrts_dp.sv @@
// Datapath of the scheduler core: task table, configuration registers, result registers.
// Depends on rrts_pkg; acts on t_cmd from rrts_ctrl and reports t_sts.
module rrts_dp #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int SLICE_BITS = rrts_pkg::SLICE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [23:0]    i_cfg_data,
    input  logic [2:0]     i_opcode,
    input  logic [3:0]     i_task_id,
    input  logic           i_exec_mark,
    input  logic           i_fifo_mode,
    input  logic [23:0]    i_counter_value,
    input  rrts_pkg::t_cmd i_cmd,
    output rrts_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [3:0]     o_result_task,
    output logic [3:0]     o_current_task,
    output logic [23:0]    o_slice_load,
    output logic           o_tick_enable,
    output logic [63:0]    o_task_time,
    output logic [1:0]     o_status
);
    import rrts_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    logic [23:0] r_reload, r_min;
    logic [4:0]  r_tasks;

    logic [TASK_SLOTS-1:0] r_used, r_exec, r_fifo;
    logic [SLICE_BITS-1:0] r_slice [TASK_SLOTS];
    logic [63:0]           r_rt    [TASK_SLOTS];
    logic [IW-1:0]         r_run;

    logic [2:0]  r_op;
    logic [3:0]  r_id;
    logic        r_ex, r_ff;
    logic [23:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic        r_any;
    logic [3:0]  r_res;
    logic [63:0] r_time;
    logic [1:0]  r_stat;

    logic [CW-1:0]         total;
    logic [7:0]            id_ext, run_ext, idx_ext;
    logic [IW-1:0]         id_ix, ix;
    logic [SLICE_BITS-1:0] reload_s;
    logic [63:0]           reload64;
    logic                  ge_min, slice0_low, id_ok;

    always_comb begin
        if (r_tasks == 5'd0) begin
            total = CW'(1);
        end else if (32'(r_tasks) > 32'(TASK_SLOTS)) begin
            total = CW'(TASK_SLOTS);
        end else begin
            total = CW'(r_tasks);
        end
    end

    assign id_ext   = 8'(r_id);
    assign run_ext  = 8'(r_run);
    assign idx_ext  = 8'(r_idx);
    assign id_ix    = id_ext[IW-1:0];
    assign ix       = idx_ext[IW-1:0];
    assign id_ok    = id_ext < 8'(total);
    assign reload_s = SLICE_BITS'(r_reload);
    assign reload64 = 64'(reload_s);
    assign ge_min     = 32'(r_slice[ix]) >= 32'(r_min);
    assign slice0_low = 32'(r_slice[0]) < 32'(r_min);

    assign o_sts.op       = r_op;
    assign o_sts.idx_end  = r_idx >= total;
    assign o_sts.hit      = r_exec[ix] && (ge_min || r_fifo[ix]);
    assign o_sts.free     = !r_used[ix];
    assign o_sts.any_left = r_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= RELOAD_RESET;
            r_min    <= MIN_SLICE_RESET;
            r_tasks  <= TASKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RELOAD: r_reload <= i_cfg_data;
                CFG_MIN:    r_min    <= i_cfg_data;
                CFG_TASKS:  r_tasks  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // task table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= TASK_SLOTS'(1);
            r_exec <= TASK_SLOTS'(1);
            r_fifo <= '0;
            r_run  <= '0;
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_slice[k] <= SLICE_BITS'(RELOAD_RESET);
                r_rt[k]    <= '0;
            end
        end else begin
            if (i_cmd.exec_op && id_ok) begin
                if (r_op == OP_DELETE && r_id != 4'd0) begin
                    r_used[id_ix] <= 1'b0;
                    r_exec[id_ix] <= 1'b0;
                end else if (r_op == OP_MARKS) begin
                    r_exec[id_ix] <= r_ex;
                    r_fifo[id_ix] <= r_ff;
                end
            end
            if (i_cmd.alloc_do) begin
                r_used[ix]  <= 1'b1;
                r_exec[ix]  <= 1'b0;
                r_fifo[ix]  <= r_ff;
                r_rt[ix]    <= '0;
                r_slice[ix] <= reload_s;
            end
            if (i_cmd.set_rem) begin
                r_slice[r_run] <= (r_op == OP_SWITCH) ? SLICE_BITS'(r_cnt) : '0;
            end
            if (i_cmd.root_fix && slice0_low) begin
                r_slice[0] <= reload_s;
                r_rt[0]    <= r_rt[0] + reload64;
            end
            if (i_cmd.charge && r_exec[ix]) begin
                r_rt[ix]    <= r_rt[ix] + reload64 - 64'(r_slice[ix]);
                r_slice[ix] <= reload_s;
            end
            if (i_cmd.set_run_idx) begin
                r_run <= ix;
            end else if (i_cmd.set_run_root) begin
                r_run <= '0;
            end
        end
    end

    // operation registers and walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_opcode;
            r_id   <= i_task_id;
            r_ex   <= i_exec_mark;
            r_ff   <= i_fifo_mode;
            r_cnt  <= i_counter_value;
            r_res  <= '0;
            r_time <= '0;
            r_stat <= ST_OK;
        end
        if (i_cmd.exec_op && !id_ok &&
            (r_op == OP_DELETE || r_op == OP_MARKS || r_op == OP_QUERY)) begin
            r_stat <= ST_RANGE;
        end
        if (i_cmd.exec_op && r_op == OP_DELETE && r_id == 4'd0) begin
            r_stat <= ST_RANGE;
        end
        if (i_cmd.exec_op && id_ok && r_op == OP_QUERY) begin
            if (id_ext == run_ext) begin
                r_time <= r_rt[id_ix] + reload64 - 64'(r_cnt);
            end else begin
                r_time <= r_rt[id_ix] + reload64 - 64'(r_slice[id_ix]);
            end
        end
        if (i_cmd.alloc_do) begin
            r_res <= idx_ext[3:0];
        end
        if (i_cmd.alloc_fail) begin
            r_stat <= ST_NOFREE;
        end
        if (i_cmd.root_fix) begin
            r_any <= 1'b0;
        end else if (i_cmd.scan_chk && r_exec[ix] && ge_min) begin
            r_any <= 1'b1;
        end
        priority if (i_cmd.idx_one) begin
            r_idx <= CW'(1);
        end else if (i_cmd.idx_run) begin
            r_idx <= CW'(r_run) + CW'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            o_result_task  <= r_res;
            o_current_task <= run_ext[3:0];
            o_slice_load   <= r_fifo[r_run] ? '0 : 24'(r_slice[r_run]);
            o_tick_enable  <= !r_fifo[r_run];
            o_task_time    <= r_time;
            o_status       <= r_stat;
        end
    end

endmodule

@@ hw/rtl/rrts_checker.sv @@
// Port-level checks for the scheduler core, bound to the top level.
// Depends only on the top level's ports.
module rrts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [23:0] o_slice_load,
    input logic        o_tick_enable,
    input logic [1:0]  o_status
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted operation did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_fifo_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tick_enable) |-> (o_slice_load == 24'd0))
        else $error("fifo task with nonzero slice load");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_slice_load  (o_slice_load),
    .o_tick_enable (o_tick_enable),
    .o_status      (o_status)
);
